>>> hw/rtl/accel_command_smoother_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the acceleration command smoother
// Concurrent property macros used at the end of the top level. Without
// SYNTHESIS they expand to labelled assertions that report through $error;
// with SYNTHESIS they expand to nothing.
// ----------------------------------------------------------------------------
`ifndef ACCEL_COMMAND_SMOOTHER_CORE_ASSERT_SVH
`define ACCEL_COMMAND_SMOOTHER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ACS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("accel smoother: same-cycle check failed");
// Next-cycle implication.
`define ACS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("accel smoother: next-cycle check failed");
`else
`define ACS_ASSERT_IMP(label, clk, rst, ante, cons)
`define ACS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/acs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Acceleration command smoother package
// Widths, register indexes, datapath operations and the microcode program
// shared by the channel interfaces and the smoother core.
// ----------------------------------------------------------------------------
package acs_pkg;

   // Field and storage widths.
   localparam int AccelWidth    = 16;
   localparam int WindowMax     = 64;
   localparam int SlotWidth     = $clog2(WindowMax);
   localparam int CountWidth    = $clog2(WindowMax + 1);
   localparam int SumWidth      = AccelWidth + SlotWidth;
   localparam int LimWidth      = AccelWidth + 2;
   localparam int LenWidth      = 7;
   localparam int RiseWidth     = AccelWidth - 1;
   localparam int CsrIndexWidth = 3;
   localparam int DivCntWidth   = $clog2(SumWidth);
   localparam logic [DivCntWidth-1:0] DivLast = DivCntWidth'(SumWidth - 1);
   localparam int PcWidth       = 4;

   // Configuration register indexes.
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_WINDOW_LENGTH     = 3'd0,
      CSR_USE_MEASURED_PREV = 3'd1,
      CSR_ACCEL_MIN         = 3'd2,
      CSR_ACCEL_MAX         = 3'd3,
      CSR_RISE_STEP_MAX     = 3'd4,
      CSR_FALL_STEP         = 3'd5
   } csr_index_type;

   // Datapath operations selected by the control word.
   typedef enum logic [3:0] {
      OP_ADMIT    = 4'd0,
      OP_EVICT    = 4'd1,
      OP_PUSH     = 4'd2,
      OP_DIV_INIT = 4'd3,
      OP_DIV_STEP = 4'd4,
      OP_DIV_SIGN = 4'd5,
      OP_LIMIT    = 4'd6,
      OP_CLAMP    = 4'd7,
      OP_ZERO     = 4'd8
   } dp_op_type;

   // Jump conditions.
   typedef enum logic [1:0] {
      JMP_NEXT     = 2'd0,
      JMP_NO_PATH  = 2'd1,
      JMP_DIV_MORE = 2'd2
   } jmp_type;

   // Program addresses.
   localparam logic [PcWidth-1:0] PC_ADMIT    = 4'd0;
   localparam logic [PcWidth-1:0] PC_EVICT    = 4'd1;
   localparam logic [PcWidth-1:0] PC_PUSH     = 4'd2;
   localparam logic [PcWidth-1:0] PC_DIV_INIT = 4'd3;
   localparam logic [PcWidth-1:0] PC_DIV_STEP = 4'd4;
   localparam logic [PcWidth-1:0] PC_DIV_SIGN = 4'd5;
   localparam logic [PcWidth-1:0] PC_LIMIT    = 4'd6;
   localparam logic [PcWidth-1:0] PC_CLAMP    = 4'd7;
   localparam logic [PcWidth-1:0] PC_ZERO     = 4'd8;

   // One control word: operation, jump condition and target, end of program.
   typedef struct packed {
      dp_op_type              op;
      jmp_type                jmp;
      logic [PcWidth-1:0]     target;
      logic                   last;
   } ucode_type;

   // The program ROM.
   function automatic ucode_type ucode_word(input logic [PcWidth-1:0] pc);
      ucode_type w;
      case (pc)
         PC_ADMIT:    w = '{OP_ADMIT,    JMP_NO_PATH,  PC_ZERO,     1'b0};
         PC_EVICT:    w = '{OP_EVICT,    JMP_NEXT,     PC_ADMIT,    1'b0};
         PC_PUSH:     w = '{OP_PUSH,     JMP_NEXT,     PC_ADMIT,    1'b0};
         PC_DIV_INIT: w = '{OP_DIV_INIT, JMP_NEXT,     PC_ADMIT,    1'b0};
         PC_DIV_STEP: w = '{OP_DIV_STEP, JMP_DIV_MORE, PC_DIV_STEP, 1'b0};
         PC_DIV_SIGN: w = '{OP_DIV_SIGN, JMP_NEXT,     PC_ADMIT,    1'b0};
         PC_LIMIT:    w = '{OP_LIMIT,    JMP_NEXT,     PC_ADMIT,    1'b0};
         PC_CLAMP:    w = '{OP_CLAMP,    JMP_NEXT,     PC_ADMIT,    1'b1};
         PC_ZERO:     w = '{OP_ZERO,     JMP_NEXT,     PC_ADMIT,    1'b1};
         default:     w = '{OP_ZERO,     JMP_NEXT,     PC_ADMIT,    1'b1};
      endcase
      return w;
   endfunction

endpackage

>>> hw/rtl/acs_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoother request channel
// Carries one raw acceleration command with its measured acceleration and
// path flag per transfer.
// ----------------------------------------------------------------------------
interface acs_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [acs_pkg::AccelWidth-1:0] raw_accel;
   logic signed [acs_pkg::AccelWidth-1:0] measured_accel;
   logic                                  path_present;

   modport source (output valid, raw_accel, measured_accel, path_present, input ready);
   modport sink   (input valid, raw_accel, measured_accel, path_present, output ready);
endinterface

>>> hw/rtl/acs_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoother response channel
// Carries one shaped acceleration command per transfer.
// ----------------------------------------------------------------------------
interface acs_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [acs_pkg::AccelWidth-1:0] accel_command;

   modport source (output valid, accel_command, input ready);
   modport sink   (input valid, accel_command, output ready);
endinterface

>>> hw/rtl/acs_csr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoother configuration write channel
// Carries a register index and its write data per transfer.
// ----------------------------------------------------------------------------
interface acs_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [acs_pkg::CsrIndexWidth-1:0]    reg_index;
   logic [acs_pkg::AccelWidth-1:0]       write_data;

   modport source (output valid, reg_index, write_data, input ready);
   modport sink   (input valid, reg_index, write_data, output ready);
endinterface

>>> hw/rtl/acs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, with registered read data.
// ----------------------------------------------------------------------------
module acs_ram #(
   parameter int Width = 16,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/accel_command_smoother_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Acceleration command smoother core
// Moving average over a sliding window of raw commands, rate limited against
// the previous (or measured) acceleration and clamped to a configured range.
// ----------------------------------------------------------------------------
// One request is processed at a time. Most of the work for a request with a
// path is the shift-subtract divider that forms the window mean, one
// iteration per bit of the 22-bit window sum, run by a small microcode
// program over one shared datapath. A request without a path jumps from the
// admit step straight to the zero step and answers 0. The finished result
// waits in an output register, so the next request is taken while the result
// is still pending; the program stalls in its final step only if the previous
// result has not yet been taken. The sample window lives in a RAM and needs
// no clearing pass after reset: the fill count ensures only written entries
// are read. Writing window_length restarts warm-up. Configuration writes are
// always accepted and are meant to be issued while no request is in flight.
// ----------------------------------------------------------------------------
`include "accel_command_smoother_core_assert.svh"

module accel_command_smoother_core (
   input  logic      clock,
   input  logic      reset,
   acs_req_if.sink   req_chan,
   acs_rsp_if.source rsp_chan,
   acs_csr_if.sink   csr_chan
);

   // Sign extension helpers.
   function automatic logic signed [acs_pkg::LimWidth-1:0] ext_lim(
      input logic signed [acs_pkg::AccelWidth-1:0] v);
      return {{(acs_pkg::LimWidth - acs_pkg::AccelWidth){v[acs_pkg::AccelWidth-1]}}, v};
   endfunction

   function automatic logic signed [acs_pkg::SumWidth-1:0] ext_sum(
      input logic signed [acs_pkg::AccelWidth-1:0] v);
      return {{(acs_pkg::SumWidth - acs_pkg::AccelWidth){v[acs_pkg::AccelWidth-1]}}, v};
   endfunction

   // Configuration registers.
   logic [acs_pkg::LenWidth-1:0]          wl_ff, wl_in;
   logic                                  use_meas_ff, use_meas_in;
   logic signed [acs_pkg::AccelWidth-1:0] min_ff, min_in;
   logic signed [acs_pkg::AccelWidth-1:0] max_ff, max_in;
   logic [acs_pkg::RiseWidth-1:0]         rise_ff, rise_in;
   logic signed [acs_pkg::AccelWidth-1:0] fs_ff, fs_in;

   // Sequencer.
   logic                                  busy_ff, busy_in;
   logic [acs_pkg::PcWidth-1:0]           pc_ff, pc_in;
   acs_pkg::ucode_type                    cw;
   logic                                  take_jmp;
   logic                                  step_en;
   logic                                  req_fire;
   logic                                  csr_fire;

   // Latched request.
   logic signed [acs_pkg::AccelWidth-1:0] raw_ff, raw_in;
   logic signed [acs_pkg::AccelWidth-1:0] meas_ff, meas_in;
   logic                                  path_ff, path_in;

   // Window state.
   logic [acs_pkg::CountWidth-1:0]        fill_ff, fill_in;
   logic [acs_pkg::SlotWidth-1:0]         slot_ff, slot_in;
   logic signed [acs_pkg::SumWidth-1:0]   sum_ff, sum_in;
   logic                                  evict_ff, evict_in;
   logic [acs_pkg::CountWidth-1:0]        eff_len;
   logic                                  fill_lt;
   logic [acs_pkg::SlotWidth-1:0]         old_addr;
   logic                                  ram_we;
   logic [acs_pkg::AccelWidth-1:0]        ram_rdata;

   // Divider.
   logic [acs_pkg::SumWidth-1:0]          quo_ff, quo_in;
   logic [acs_pkg::CountWidth-1:0]        rem_ff, rem_in;
   logic                                  neg_ff, neg_in;
   logic [acs_pkg::DivCntWidth-1:0]       div_cnt_ff, div_cnt_in;
   logic [acs_pkg::SumWidth-1:0]          sum_mag;
   logic [acs_pkg::CountWidth:0]          rem_sh;
   logic [acs_pkg::CountWidth:0]          rem_diff;
   logic                                  div_ge;
   logic [acs_pkg::AccelWidth:0]          mean_mag;
   logic [acs_pkg::AccelWidth:0]          mean_full;

   // Limiter and clamp.
   logic signed [acs_pkg::AccelWidth-1:0] mean_ff, mean_in;
   logic signed [acs_pkg::LimWidth-1:0]   limit_ff, limit_in;
   logic signed [acs_pkg::LimWidth-1:0]   prev_x, mean_x, rise_x, fs_x, fs_abs;
   logic signed [acs_pkg::LimWidth-1:0]   diff, diff_neg, limit_res;
   logic signed [acs_pkg::LimWidth-1:0]   hi_x, lo_x, clamp_x;
   logic signed [acs_pkg::AccelWidth-1:0] clamp_res;

   // Output and history.
   logic signed [acs_pkg::AccelWidth-1:0] prev_ff, prev_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic signed [acs_pkg::AccelWidth-1:0] rsp_data_ff, rsp_data_in;

   // Handshakes.
   assign req_chan.ready         = !busy_ff;
   assign csr_chan.ready         = 1'b1;
   assign req_fire               = req_chan.valid && req_chan.ready;
   assign csr_fire               = csr_chan.valid && csr_chan.ready;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.accel_command = rsp_data_ff;

   // Effective window length, saturated to one and to the window size.
   always_comb begin
      if (wl_ff == '0) begin
         eff_len = acs_pkg::CountWidth'(1);
      end else if (acs_pkg::CountWidth'(wl_ff) > acs_pkg::CountWidth'(acs_pkg::WindowMax)) begin
         eff_len = acs_pkg::CountWidth'(acs_pkg::WindowMax);
      end else begin
         eff_len = acs_pkg::CountWidth'(wl_ff);
      end
   end

   assign fill_lt  = fill_ff < eff_len;
   assign old_addr = slot_ff - eff_len[acs_pkg::SlotWidth-1:0];

   // Control word fetch and jump decision.
   always_comb begin
      cw = acs_pkg::ucode_word(pc_ff);
      case (cw.jmp)
         acs_pkg::JMP_NEXT:     take_jmp = 1'b0;
         acs_pkg::JMP_NO_PATH:  take_jmp = !path_ff;
         acs_pkg::JMP_DIV_MORE: take_jmp = div_cnt_ff != acs_pkg::DivLast;
         default:               take_jmp = 1'b0;
      endcase
      // The final step waits while the output register still holds a result.
      step_en = busy_ff && !(cw.last && rsp_valid_ff && !rsp_chan.ready);
   end

   assign ram_we = step_en && (cw.op == acs_pkg::OP_PUSH);

   // Divider step: shift in the next dividend bit and subtract when it fits.
   always_comb begin
      sum_mag   = sum_ff[acs_pkg::SumWidth-1] ? acs_pkg::SumWidth'(-sum_ff)
                                              : acs_pkg::SumWidth'(sum_ff);
      rem_sh    = {rem_ff, quo_ff[acs_pkg::SumWidth-1]};
      rem_diff  = rem_sh - {1'b0, fill_ff};
      div_ge    = rem_sh >= {1'b0, fill_ff};
      mean_mag  = quo_ff[acs_pkg::AccelWidth:0];
      mean_full = neg_ff ? (~mean_mag + 1'b1) : mean_mag;
   end

   // Rate limiter against the previous or measured acceleration.
   always_comb begin
      prev_x   = ext_lim(use_meas_ff ? meas_ff : prev_ff);
      mean_x   = ext_lim(mean_ff);
      rise_x   = {{(acs_pkg::LimWidth - acs_pkg::RiseWidth){1'b0}}, rise_ff};
      fs_x     = ext_lim(fs_ff);
      fs_abs   = fs_x[acs_pkg::LimWidth-1] ? -fs_x : fs_x;
      diff     = mean_x - prev_x;
      diff_neg = -diff;
      if (!diff[acs_pkg::LimWidth-1] && (diff > rise_x)) begin
         limit_res = prev_x + rise_x;
      end else if (diff[acs_pkg::LimWidth-1] && (diff_neg > fs_abs)) begin
         limit_res = prev_x + fs_x;
      end else begin
         limit_res = mean_x;
      end
   end

   // Clamp: maximum first, then minimum.
   always_comb begin
      hi_x    = ext_lim(max_ff);
      lo_x    = ext_lim(min_ff);
      clamp_x = limit_ff;
      if (clamp_x > hi_x) begin
         clamp_x = hi_x;
      end
      if (clamp_x < lo_x) begin
         clamp_x = lo_x;
      end
      clamp_res = clamp_x[acs_pkg::AccelWidth-1:0];
   end

   // Next-state logic for the sequencer, datapath and configuration.
   always_comb begin
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      raw_in       = raw_ff;
      meas_in      = meas_ff;
      path_in      = path_ff;
      fill_in      = fill_ff;
      slot_in      = slot_ff;
      sum_in       = sum_ff;
      evict_in     = evict_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      div_cnt_in   = div_cnt_ff;
      mean_in      = mean_ff;
      limit_in     = limit_ff;
      prev_in      = prev_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wl_in        = wl_ff;
      use_meas_in  = use_meas_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      rise_in      = rise_ff;
      fs_in        = fs_ff;

      // The pending result leaves on its transfer.
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Start a new program run on an accepted request.
      if (req_fire) begin
         busy_in = 1'b1;
         pc_in   = acs_pkg::PC_ADMIT;
         raw_in  = req_chan.raw_accel;
         meas_in = req_chan.measured_accel;
         path_in = req_chan.path_present;
      end

      if (step_en) begin
         // Program counter.
         if (cw.last) begin
            busy_in = 1'b0;
         end else if (take_jmp) begin
            pc_in = cw.target;
         end else begin
            pc_in = pc_ff + 1'b1;
         end

         // Datapath operation.
         case (cw.op)
            acs_pkg::OP_ADMIT: begin
               if (path_ff) begin
                  evict_in = !fill_lt;
                  if (fill_lt) begin
                     fill_in = fill_ff + 1'b1;
                  end
               end
            end
            acs_pkg::OP_EVICT: begin
               if (evict_ff) begin
                  sum_in = sum_ff - ext_sum(ram_rdata);
               end
            end
            acs_pkg::OP_PUSH: begin
               sum_in  = sum_ff + ext_sum(raw_ff);
               slot_in = slot_ff + 1'b1;
            end
            acs_pkg::OP_DIV_INIT: begin
               quo_in     = sum_mag;
               neg_in     = sum_ff[acs_pkg::SumWidth-1];
               rem_in     = '0;
               div_cnt_in = '0;
            end
            acs_pkg::OP_DIV_STEP: begin
               rem_in     = div_ge ? rem_diff[acs_pkg::CountWidth-1:0]
                                   : rem_sh[acs_pkg::CountWidth-1:0];
               quo_in     = {quo_ff[acs_pkg::SumWidth-2:0], div_ge};
               div_cnt_in = div_cnt_ff + 1'b1;
            end
            acs_pkg::OP_DIV_SIGN: begin
               mean_in = mean_full[acs_pkg::AccelWidth-1:0];
            end
            acs_pkg::OP_LIMIT: begin
               limit_in = limit_res;
            end
            acs_pkg::OP_CLAMP: begin
               prev_in      = clamp_res;
               rsp_data_in  = clamp_res;
               rsp_valid_in = 1'b1;
            end
            acs_pkg::OP_ZERO: begin
               prev_in      = '0;
               rsp_data_in  = '0;
               rsp_valid_in = 1'b1;
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end

      // Configuration writes; a window length write restarts warm-up.
      if (csr_fire) begin
         case (csr_chan.reg_index)
            acs_pkg::CSR_WINDOW_LENGTH: begin
               wl_in   = csr_chan.write_data[acs_pkg::LenWidth-1:0];
               fill_in = '0;
               slot_in = '0;
               sum_in  = '0;
            end
            acs_pkg::CSR_USE_MEASURED_PREV: use_meas_in = csr_chan.write_data[0];
            acs_pkg::CSR_ACCEL_MIN:         min_in      = csr_chan.write_data;
            acs_pkg::CSR_ACCEL_MAX:         max_in      = csr_chan.write_data;
            acs_pkg::CSR_RISE_STEP_MAX: begin
               rise_in = csr_chan.write_data[acs_pkg::RiseWidth-1:0];
            end
            acs_pkg::CSR_FALL_STEP:         fs_in       = csr_chan.write_data;
            default: begin
               wl_in = wl_ff;
            end
         endcase
      end
   end

   // Control and state registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= acs_pkg::PC_ADMIT;
         fill_ff      <= '0;
         slot_ff      <= '0;
         sum_ff       <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         wl_ff        <= acs_pkg::LenWidth'(1);
         use_meas_ff  <= 1'b0;
         min_ff       <= {1'b1, {(acs_pkg::AccelWidth - 1){1'b0}}};
         max_ff       <= {1'b0, {(acs_pkg::AccelWidth - 1){1'b1}}};
         rise_ff      <= '1;
         fs_ff        <= {1'b1, {(acs_pkg::AccelWidth - 1){1'b0}}};
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         fill_ff      <= fill_in;
         slot_ff      <= slot_in;
         sum_ff       <= sum_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
         wl_ff        <= wl_in;
         use_meas_ff  <= use_meas_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rise_ff      <= rise_in;
         fs_ff        <= fs_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      raw_ff      <= raw_in;
      meas_ff     <= meas_in;
      path_ff     <= path_in;
      evict_ff    <= evict_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      div_cnt_ff  <= div_cnt_in;
      mean_ff     <= mean_in;
      limit_ff    <= limit_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Sample window storage.
   acs_ram #(
      .Width (acs_pkg::AccelWidth),
      .Depth (acs_pkg::WindowMax)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot_ff),
      .wr_data (raw_ff),
      .rd_addr (old_addr),
      .rd_data (ram_rdata)
   );

   // An accepted request always starts the program at its first step.
   `ACS_ASSERT_NXT(a_start_at_admit, clock, reset, req_fire, busy_ff && (pc_ff == acs_pkg::PC_ADMIT))
   // The window never holds more samples than its effective length.
   `ACS_ASSERT_IMP(a_fill_bounded, clock, reset, 1'b1, fill_ff <= eff_len)
   // The divider remainder stays below the divisor once the quotient is done.
   `ACS_ASSERT_IMP(a_rem_below_div, clock, reset, busy_ff && (pc_ff == acs_pkg::PC_DIV_SIGN), rem_ff < fill_ff)
   // A pending result is always the value kept as the previous output.
   `ACS_ASSERT_IMP(a_prev_matches, clock, reset, rsp_valid_ff, prev_ff == rsp_data_ff)

endmodule

>>> test/tb_accel_command_smoother_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Acceleration command smoother testbench
// Drives raw commands into the smoother core, mirrors its window average,
// rate limiter and clamp in a behavioural predictor, and compares every
// response transfer with the oldest prediction. A directed table is followed
// by random phases under several register settings, with random idle bursts
// on the request and response channels.
// ----------------------------------------------------------------------------
module tb_accel_command_smoother_core;
   import acs_pkg::*;

   localparam int CLOCK_HALF_NS = 6;
   localparam int RESET_CYCLES = 4;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES = 40;
   localparam int TIMEOUT_NS = 5_000_000;
   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 78;
   localparam int DIRECTED_COUNT = 41;

   // Register indexes that the core decodes to nothing.
   localparam logic [CsrIndexWidth-1:0] CSR_UNUSED_A = 3'd6;
   localparam logic [CsrIndexWidth-1:0] CSR_UNUSED_B = 3'd7;

   typedef enum logic {
      ROW_REQUEST,
      ROW_WRITE
   } row_kind_type;

   // One line of the directed table: either a register write or a request,
   // optionally with its response written out by hand.
   typedef struct packed {
      row_kind_type             kind;
      logic [CsrIndexWidth-1:0] reg_index;
      int                       reg_data;
      int                       raw;
      int                       meas;
      logic                     path;
      logic                     typed;
      int                       typed_command;
   } step_row_type;

   logic clock = 1'b0;
   logic reset;

   acs_req_if req_bus ();
   acs_rsp_if rsp_bus ();
   acs_csr_if csr_bus ();

   accel_command_smoother_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Mirror of the register file, at reset values.
   logic [LenWidth-1:0]          cfg_window_length = 7'd1;
   logic                         cfg_use_measured = 1'b0;
   logic signed [AccelWidth-1:0] cfg_accel_min = 16'sh8000;
   logic signed [AccelWidth-1:0] cfg_accel_max = 16'sh7FFF;
   logic [RiseWidth-1:0]         cfg_rise_step = 15'h7FFF;
   logic signed [AccelWidth-1:0] cfg_fall_step = 16'sh8000;

   // Mirror of the sliding window and the previous command.
   logic signed [AccelWidth-1:0] sample_ring [WindowMax];
   int                           held_count = 0;
   int                           next_slot = 0;
   longint                       ring_sum = 0;
   logic signed [AccelWidth-1:0] last_command = '0;

   logic signed [AccelWidth-1:0] pending_commands [$];
   logic signed [AccelWidth-1:0] expected_command;
   int                           failure_count = 0;
   int                           stall_left = 0;
   bit                           quiet_tail = 1'b0;
   step_row_type                 directed_rows [DIRECTED_COUNT];

   always #(CLOCK_HALF_NS) clock = ~clock;

   // Applies one register write to the mirrored configuration.
   function automatic void store_register(input logic [CsrIndexWidth-1:0] reg_index,
                                          input logic [AccelWidth-1:0] data);
      case (reg_index)
         CSR_WINDOW_LENGTH: begin
            cfg_window_length = data[LenWidth-1:0];
            held_count = 0;
            next_slot = 0;
            ring_sum = 0;
         end
         CSR_USE_MEASURED_PREV: cfg_use_measured = data[0];
         CSR_ACCEL_MIN: cfg_accel_min = data;
         CSR_ACCEL_MAX: cfg_accel_max = data;
         CSR_RISE_STEP_MAX: cfg_rise_step = data[RiseWidth-1:0];
         CSR_FALL_STEP: cfg_fall_step = data;
         default: ;
      endcase
   endfunction

   // Works out the command that one accepted request must produce and
   // advances the mirrored window.
   function automatic logic signed [AccelWidth-1:0] shape_command(input int raw_in,
                                                                  input int meas_in,
                                                                  input bit path);
      logic signed [AccelWidth-1:0] sample;
      logic signed [AccelWidth-1:0] measured;
      int     span;
      longint mean, prev, diff, rise, fall, fall_mag, outcome;
      sample = AccelWidth'(raw_in);
      measured = AccelWidth'(meas_in);
      if (!path) begin
         outcome = 0;
      end else begin
         // A length of zero acts as one; lengths past the store saturate.
         span = (cfg_window_length == 0) ? 1 :
                (cfg_window_length > WindowMax) ? WindowMax : int'(cfg_window_length);
         if (held_count < span) begin
            held_count++;
         end else begin
            ring_sum -= sample_ring[(next_slot + WindowMax - span) % WindowMax];
         end
         sample_ring[next_slot] = sample;
         ring_sum += sample;
         next_slot = (next_slot + 1) % WindowMax;
         mean = ring_sum / held_count;

         // Rate limit against the previous or the measured acceleration.
         prev = cfg_use_measured ? measured : last_command;
         rise = cfg_rise_step;
         fall = cfg_fall_step;
         fall_mag = (fall < 0) ? -fall : fall;
         diff = mean - prev;
         outcome = mean;
         if (diff >= 0 && diff > rise) begin
            outcome = prev + rise;
         end else if (diff < 0 && -diff > fall_mag) begin
            outcome = prev + fall;
         end

         // The upper bound is applied first, so the lower one wins.
         if (outcome > cfg_accel_max) outcome = cfg_accel_max;
         if (outcome < cfg_accel_min) outcome = cfg_accel_min;
      end
      last_command = AccelWidth'(outcome);
      return last_command;
   endfunction

   function automatic int saturate16(input int value);
      if (value > 32767) return 32767;
      if (value < -32768) return -32768;
      return value;
   endfunction

   // Full-scale ends, zero, values near zero, or any 16-bit value.
   function automatic int pick_accel();
      case ($urandom_range(0, 5))
         0: return -32768;
         1: return 32767;
         2: return 0;
         3: return int'($urandom_range(0, 4000)) - 2000;
         default: return int'($signed(16'($urandom)));
      endcase
   endfunction

   function automatic step_row_type request_row(input int raw, input int meas, input bit path);
      return '{ROW_REQUEST, CSR_WINDOW_LENGTH, 0, raw, meas, path, 1'b0, 0};
   endfunction

   function automatic step_row_type known_row(input int raw, input int meas, input bit path,
                                              input int command);
      return '{ROW_REQUEST, CSR_WINDOW_LENGTH, 0, raw, meas, path, 1'b1, command};
   endfunction

   function automatic step_row_type register_row(input logic [CsrIndexWidth-1:0] reg_index,
                                                 input int data);
      return '{ROW_WRITE, reg_index, data, 0, 0, 1'b0, 1'b0, 0};
   endfunction

   // Lowers the request valid and waits until every response has come back,
   // then lets the core finish its last program pass.
   task automatic drain_block();
      req_bus.valid <= 1'b0;
      while (pending_commands.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CsrIndexWidth-1:0] reg_index,
                                 input logic [AccelWidth-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.reg_index <= reg_index;
      csr_bus.write_data <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      store_register(reg_index, data);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Offers one request, after an optional idle burst, and records the
   // command it must produce once the transfer has taken place.
   task automatic send_request(input int raw, input int meas, input bit path,
                               input bit typed, input int typed_command);
      logic signed [AccelWidth-1:0] predicted;
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.raw_accel <= AccelWidth'(raw);
      req_bus.measured_accel <= AccelWidth'(meas);
      req_bus.path_present <= path;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = shape_command(raw, meas, path);
      if (typed) begin
         predicted = AccelWidth'(typed_command);
      end
      pending_commands = {pending_commands, predicted};
   endtask

   // Response side: check each transfer, then choose the next ready value.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_commands.size() == 0) begin
            $error("accel_command: no transfer expected, actual %0d",
                   rsp_bus.accel_command);
            failure_count++;
         end else begin
            expected_command = pending_commands.pop_front();
            if (rsp_bus.accel_command !== expected_command) begin
               $error("accel_command: expected %0d, actual %0d",
                      expected_command, rsp_bus.accel_command);
               failure_count++;
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 15);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Stimulus: directed table first, then random phases.
   initial begin
      int raw_level;
      int meas_value;
      int span;
      int lower;
      int upper;
      int swap_value;
      int rise;
      int fall;
      bit path;

      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.raw_accel <= '0;
      req_bus.measured_accel <= '0;
      req_bus.path_present <= 1'b0;
      csr_bus.valid <= 1'b0;
      csr_bus.reg_index <= CSR_WINDOW_LENGTH;
      csr_bus.write_data <= '0;
      raw_level = 0;

      directed_rows = '{
         // Reset settings: a window of one, wide limits, previous output zero.
         known_row(0, 0, 1, 0),
         known_row(32767, 0, 1, 32767),
         // A full-scale drop is cut short by the fall step.
         known_row(-32768, 0, 1, -1),
         known_row(-32768, 0, 1, -32768),
         // A full-scale rise is cut short by the rise step.
         known_row(32767, -1, 1, -1),
         // Without a path the answer is zero.
         known_row(12345, -32768, 0, 0),
         known_row(-32768, 32767, 0, 0),
         // A window length of zero behaves as one.
         register_row(CSR_WINDOW_LENGTH, 0),
         known_row(500, 0, 1, 500),
         // An oversized length saturates; warm-up averages what is held.
         register_row(CSR_WINDOW_LENGTH, 100),
         request_row(1000, 0, 1),
         request_row(-3, 0, 1),
         request_row(-32768, 0, 1),
         known_row(32767, 0, 0, 0),
         request_row(-32768, 0, 1),
         // Measured acceleration as reference, tight rise and a positive fall.
         register_row(CSR_USE_MEASURED_PREV, 1),
         register_row(CSR_RISE_STEP_MAX, 10),
         register_row(CSR_FALL_STEP, 7),
         request_row(2000, 0, 1),
         request_row(-30000, 5000, 1),
         request_row(32767, -32768, 1),
         // Minimum above maximum: the minimum wins.
         register_row(CSR_ACCEL_MIN, 100),
         register_row(CSR_ACCEL_MAX, -100),
         known_row(50, -5, 1, 100),
         known_row(-50, 0, 0, 0),
         // Writes to undecoded indexes change nothing.
         register_row(CSR_UNUSED_A, 16'hFFFF),
         register_row(CSR_UNUSED_B, 16'h1234),
         known_row(7, 0, 1, 100),
         register_row(CSR_ACCEL_MIN, -32768),
         register_row(CSR_ACCEL_MAX, 32767),
         register_row(CSR_RISE_STEP_MAX, 32767),
         register_row(CSR_FALL_STEP, -32768),
         register_row(CSR_USE_MEASURED_PREV, 0),
         // A short window that slides, with negative means truncated toward zero.
         register_row(CSR_WINDOW_LENGTH, 3),
         request_row(9, 0, 1),
         request_row(-20, 0, 1),
         request_row(4, 0, 1),
         request_row(-7, 0, 1),
         // Upper data bits are ignored by the length register.
         register_row(CSR_WINDOW_LENGTH, 16'hFF7F),
         request_row(-5, 0, 1),
         request_row(2, 0, 1)
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            drain_block();
            write_register(directed_rows[i].reg_index, AccelWidth'(directed_rows[i].reg_data));
         end else begin
            send_request(directed_rows[i].raw, directed_rows[i].meas, directed_rows[i].path,
                         directed_rows[i].typed, directed_rows[i].typed_command);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         // Registers change only once the core has gone quiet.
         drain_block();
         quiet_tail <= (phase == RANDOM_PHASES - 1);
         case (phase)
            0: begin
               write_register(CSR_WINDOW_LENGTH, 16'(WindowMax));
               write_register(CSR_USE_MEASURED_PREV, 16'(0));
               write_register(CSR_ACCEL_MIN, 16'(-32768));
               write_register(CSR_ACCEL_MAX, 16'(32767));
               write_register(CSR_RISE_STEP_MAX, 16'(32767));
               write_register(CSR_FALL_STEP, 16'(-32768));
            end
            1: begin
               write_register(CSR_WINDOW_LENGTH, 16'(2));
               write_register(CSR_USE_MEASURED_PREV, 16'(1));
               write_register(CSR_RISE_STEP_MAX, 16'(0));
               write_register(CSR_FALL_STEP, 16'(0));
            end
            default: begin
               if ($urandom_range(0, 3) != 0) begin
                  case ($urandom_range(0, 5))
                     0: span = 0;
                     1: span = WindowMax;
                     2: span = $urandom_range(WindowMax + 1, 127);
                     3, 4: span = $urandom_range(1, 8);
                     default: span = $urandom_range(1, WindowMax);
                  endcase
                  write_register(CSR_WINDOW_LENGTH, 16'({$urandom_range(0, 511), 7'(span)}));
               end
               if ($urandom_range(0, 3) != 0) begin
                  write_register(CSR_USE_MEASURED_PREV,
                                 16'({$urandom_range(0, 32767), 1'($urandom_range(0, 1))}));
               end
               lower = pick_accel();
               upper = pick_accel();
               if (lower > upper && $urandom_range(0, 3) != 0) begin
                  swap_value = lower;
                  lower = upper;
                  upper = swap_value;
               end
               if ($urandom_range(0, 3) != 0) write_register(CSR_ACCEL_MIN, 16'(lower));
               if ($urandom_range(0, 3) != 0) write_register(CSR_ACCEL_MAX, 16'(upper));
               case ($urandom_range(0, 4))
                  0: rise = 0;
                  1: rise = 32767;
                  2, 3: rise = $urandom_range(1, 200);
                  default: rise = $urandom_range(0, 32767);
               endcase
               if ($urandom_range(0, 3) != 0) begin
                  write_register(CSR_RISE_STEP_MAX,
                                 16'({1'($urandom_range(0, 1)), 15'(rise)}));
               end
               case ($urandom_range(0, 2))
                  0: fall = int'($urandom_range(1, 300));
                  default: fall = pick_accel();
               endcase
               if ($urandom_range(0, 3) != 0) write_register(CSR_FALL_STEP, 16'(fall));
               if ($urandom_range(0, 3) == 0) begin
                  write_register($urandom_range(0, 1) ? CSR_UNUSED_A : CSR_UNUSED_B,
                                 16'($urandom));
               end
            end
         endcase

         // Mostly a drifting command with a nearby measurement, with jumps
         // to the extremes and the occasional tick without a path.
         for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
            case ($urandom_range(0, 9))
               0, 1: raw_level = pick_accel();
               default: raw_level = saturate16(raw_level + int'($urandom_range(0, 2000)) - 1000);
            endcase
            case ($urandom_range(0, 3))
               0: meas_value = pick_accel();
               default: meas_value = saturate16(raw_level + int'($urandom_range(0, 600)) - 300);
            endcase
            path = ($urandom_range(0, 11) != 0);
            send_request(raw_level, meas_value, path, 1'b0, 0);
         end
      end

      drain_block();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failure_count == 0 && pending_commands.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(TIMEOUT_NS);
      $display("Some tests failed");
      $finish;
   end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/acs_pkg.sv
hw/rtl/acs_req_if.sv
hw/rtl/acs_rsp_if.sv
hw/rtl/acs_csr_if.sv
hw/rtl/acs_ram.sv
hw/rtl/accel_command_smoother_core.sv
test/tb_accel_command_smoother_core.sv
